// ===== rtl/ehci_rb_pkg.sv =====
// Shared types and constants for the EHCI host register bank.
// Used by ehci_rb_decode and ehci_host_register_bank; no dependencies.
`timescale 1ns / 1ps

package ehci_rb_pkg;

   localparam int DEFAULT_MAX_PORTS = 8;

   localparam int OFFSET_W   = 12;
   localparam int DATA_W     = 32;
   localparam int PORT_NUM_W = 4;

   // Request kinds.
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // Register offsets.
   localparam logic [OFFSET_W-1:0] OFS_CAP_LENGTH   = 12'h000;
   localparam logic [OFFSET_W-1:0] OFS_HCS_PARAMS   = 12'h004;
   localparam logic [OFFSET_W-1:0] OFS_HCC_PARAMS   = 12'h008;
   localparam logic [OFFSET_W-1:0] OFS_PORT_ROUTE   = 12'h00C;
   localparam logic [OFFSET_W-1:0] OFS_COMMAND      = 12'h020;
   localparam logic [OFFSET_W-1:0] OFS_STATUS       = 12'h024;
   localparam logic [OFFSET_W-1:0] OFS_INTR_ENABLE  = 12'h028;
   localparam logic [OFFSET_W-1:0] OFS_FRAME_INDEX  = 12'h02C;
   localparam logic [OFFSET_W-1:0] OFS_SEGMENT      = 12'h030;
   localparam logic [OFFSET_W-1:0] OFS_PERIODIC     = 12'h034;
   localparam logic [OFFSET_W-1:0] OFS_ASYNC        = 12'h038;
   localparam logic [OFFSET_W-1:0] OFS_CONFIG_FLAG  = 12'h040;
   localparam logic [OFFSET_W-1:0] OFS_PORT_BASE    = 12'h044;

   // Constant register contents.
   localparam logic [15:0]       HCI_VERSION      = 16'h0100;
   localparam logic [15:0]       CAP_LENGTH       = 16'h0020;
   localparam logic [DATA_W-1:0] CAP_WORD0        = {HCI_VERSION, CAP_LENGTH};
   localparam logic [DATA_W-1:0] HCS_PARAMS_BASE  = 32'h0001_0000;
   localparam logic [DATA_W-1:0] HCC_PARAMS_VALUE = 32'h0000_0006;
   localparam logic [DATA_W-1:0] STATUS_VALUE     = 32'h0000_1000;
   localparam logic [DATA_W-1:0] CMD_RESET_MASK   = 32'h0000_0002;
   localparam logic [PORT_NUM_W-1:0] NUM_PORTS_RESET = 4'd4;

   typedef enum logic [3:0] {
      SEL_NONE,
      SEL_CAP_LENGTH,
      SEL_HCS_PARAMS,
      SEL_HCC_PARAMS,
      SEL_PORT_ROUTE,
      SEL_COMMAND,
      SEL_STATUS,
      SEL_INTR_ENABLE,
      SEL_FRAME_INDEX,
      SEL_SEGMENT,
      SEL_PERIODIC,
      SEL_ASYNC,
      SEL_CONFIG_FLAG,
      SEL_PORT
   } reg_sel_type;

   typedef struct packed {
      reg_sel_type           sel;
      logic [PORT_NUM_W-1:0] port_num;
   } decode_type;

endpackage

// ===== rtl/ehci_host_register_bank.sv =====
// EHCI host register bank: an accepted request word is held in the request register, then its
// answer is registered in the response register. Throughput one word per cycle while rsp_stall
// is low; the request register, offset decode and register file access form a single pass
// into the response register. Synchronous active-high reset clears all operational and port
// registers and sets the port count to 4. Depends on ehci_rb_pkg and ehci_rb_decode.
`timescale 1ns / 1ps

module ehci_host_register_bank #(
   parameter int MAX_PORTS = ehci_rb_pkg::DEFAULT_MAX_PORTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic [ehci_rb_pkg::OFFSET_W-1:0]    req_offset,
   input  logic [ehci_rb_pkg::DATA_W-1:0]      req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ehci_rb_pkg::DATA_W-1:0]      rsp_read_data,
   output logic                                rsp_unmapped,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ehci_rb_pkg::PORT_NUM_W-1:0]  csr_num_ports
);

   localparam int PORT_IDX_W = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
   localparam int DW = ehci_rb_pkg::DATA_W;

   logic                               s1_valid_ff, s1_valid_in;
   logic                               s1_type_ff;
   logic [ehci_rb_pkg::OFFSET_W-1:0]   s1_offset_ff;
   logic [DW-1:0]                      s1_data_ff;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                      rsp_data_ff, rsp_data_in;
   logic                               rsp_unmapped_ff, rsp_unmapped_in;

   logic [ehci_rb_pkg::PORT_NUM_W-1:0] num_ports_ff, num_ports_in;
   logic [DW-1:0] command_ff, command_in;
   logic [DW-1:0] intr_enable_ff, intr_enable_in;
   logic [DW-1:0] frame_index_ff, frame_index_in;
   logic [DW-1:0] segment_ff, segment_in;
   logic [DW-1:0] periodic_ff, periodic_in;
   logic [DW-1:0] async_ff, async_in;
   logic [DW-1:0] config_flag_ff, config_flag_in;
   logic [DW-1:0] port_status_ff [MAX_PORTS];
   logic [DW-1:0] port_status_in [MAX_PORTS];

   ehci_rb_pkg::decode_type decode;
   logic [PORT_IDX_W-1:0]   port_idx;
   logic                    req_accept;
   logic                    s2_fire;
   logic                    is_write;
   logic [DW-1:0]           read_word;
   logic                    read_miss;
   logic                    write_miss;

   ehci_rb_decode #(
      .MAX_PORTS (MAX_PORTS)
   ) u_decode (
      .offset    (s1_offset_ff),
      .num_ports (num_ports_ff),
      .decode    (decode)
   );

   assign port_idx   = decode.port_num[PORT_IDX_W-1:0];
   assign s2_fire    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s2_fire;
   assign req_accept = req_valid && !req_stall;
   assign is_write   = (s1_type_ff == ehci_rb_pkg::REQ_WRITE);

   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_unmapped  = rsp_unmapped_ff;

   // Read side of the register file.
   always_comb begin
      read_miss = 1'b0;
      unique case (decode.sel)
         ehci_rb_pkg::SEL_CAP_LENGTH:  read_word = ehci_rb_pkg::CAP_WORD0;
         ehci_rb_pkg::SEL_HCS_PARAMS: begin
            read_word = ehci_rb_pkg::HCS_PARAMS_BASE |
                        {{(DW - ehci_rb_pkg::PORT_NUM_W){1'b0}}, num_ports_ff};
         end
         ehci_rb_pkg::SEL_HCC_PARAMS:  read_word = ehci_rb_pkg::HCC_PARAMS_VALUE;
         ehci_rb_pkg::SEL_PORT_ROUTE:  read_word = '0;
         ehci_rb_pkg::SEL_COMMAND:     read_word = command_ff;
         ehci_rb_pkg::SEL_STATUS:      read_word = ehci_rb_pkg::STATUS_VALUE;
         ehci_rb_pkg::SEL_INTR_ENABLE: read_word = intr_enable_ff;
         ehci_rb_pkg::SEL_FRAME_INDEX: read_word = frame_index_ff;
         ehci_rb_pkg::SEL_SEGMENT:     read_word = segment_ff;
         ehci_rb_pkg::SEL_PERIODIC:    read_word = periodic_ff;
         ehci_rb_pkg::SEL_ASYNC:       read_word = async_ff;
         ehci_rb_pkg::SEL_CONFIG_FLAG: read_word = config_flag_ff;
         ehci_rb_pkg::SEL_PORT:        read_word = port_status_ff[port_idx];
         default: begin
            read_word = '0;
            read_miss = 1'b1;
         end
      endcase
   end

   // Capability words are read only, so a write to them counts as a miss.
   assign write_miss = (decode.sel == ehci_rb_pkg::SEL_NONE) ||
                       (decode.sel == ehci_rb_pkg::SEL_CAP_LENGTH) ||
                       (decode.sel == ehci_rb_pkg::SEL_HCS_PARAMS) ||
                       (decode.sel == ehci_rb_pkg::SEL_HCC_PARAMS) ||
                       (decode.sel == ehci_rb_pkg::SEL_PORT_ROUTE);

   // Write side of the register file.
   always_comb begin
      command_in     = command_ff;
      intr_enable_in = intr_enable_ff;
      frame_index_in = frame_index_ff;
      segment_in     = segment_ff;
      periodic_in    = periodic_ff;
      async_in       = async_ff;
      config_flag_in = config_flag_ff;
      port_status_in = port_status_ff;
      if (s2_fire && is_write) begin
         unique case (decode.sel)
            ehci_rb_pkg::SEL_COMMAND:     command_in = s1_data_ff & ~ehci_rb_pkg::CMD_RESET_MASK;
            ehci_rb_pkg::SEL_INTR_ENABLE: intr_enable_in = s1_data_ff;
            ehci_rb_pkg::SEL_FRAME_INDEX: frame_index_in = s1_data_ff;
            ehci_rb_pkg::SEL_SEGMENT:     segment_in = s1_data_ff;
            ehci_rb_pkg::SEL_PERIODIC:    periodic_in = s1_data_ff;
            ehci_rb_pkg::SEL_ASYNC:       async_in = s1_data_ff;
            ehci_rb_pkg::SEL_CONFIG_FLAG: config_flag_in = s1_data_ff;
            ehci_rb_pkg::SEL_PORT:        port_status_in[port_idx] = s1_data_ff;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      num_ports_in = csr_valid ? csr_num_ports : num_ports_ff;
      s1_valid_in  = req_accept ? 1'b1 : (s2_fire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s2_fire ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_data_in     = rsp_data_ff;
      rsp_unmapped_in = rsp_unmapped_ff;
      if (s2_fire) begin
         rsp_data_in     = is_write ? '0 : read_word;
         rsp_unmapped_in = is_write ? write_miss : read_miss;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         num_ports_ff   <= ehci_rb_pkg::NUM_PORTS_RESET;
         command_ff     <= '0;
         intr_enable_ff <= '0;
         frame_index_ff <= '0;
         segment_ff     <= '0;
         periodic_ff    <= '0;
         async_ff       <= '0;
         config_flag_ff <= '0;
         for (int i = 0; i < MAX_PORTS; i++) begin
            port_status_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         num_ports_ff   <= num_ports_in;
         command_ff     <= command_in;
         intr_enable_ff <= intr_enable_in;
         frame_index_ff <= frame_index_in;
         segment_ff     <= segment_in;
         periodic_ff    <= periodic_in;
         async_ff       <= async_in;
         config_flag_ff <= config_flag_in;
         port_status_ff <= port_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_type_ff   <= req_type;
         s1_offset_ff <= req_offset;
         s1_data_ff   <= req_write_data;
      end
      rsp_data_ff     <= rsp_data_in;
      rsp_unmapped_ff <= rsp_unmapped_in;
   end

   // The host controller reset bit never stays set in the command register.
   a_cmd_reset_clear: assert property (@(posedge clock) disable iff (reset)
      !command_ff[1])
      else $error("command register holds the reset bit");

   // A miss always returns a zero word.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_unmapped_ff |-> rsp_data_ff == '0)
      else $error("unmapped response carries data");

   // A completed write answers with a zero word.
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      s2_fire && is_write |=> rsp_valid_ff && rsp_data_ff == '0)
      else $error("write response carries data");

   // The request side stalls only while the request register is occupied.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty request register");

endmodule

// ===== rtl/ehci_rb_decode.sv =====
// Offset decoder for the EHCI host register bank.
// Depends on ehci_rb_pkg for offsets and the decode result type.
`timescale 1ns / 1ps

module ehci_rb_decode #(
   parameter int MAX_PORTS = ehci_rb_pkg::DEFAULT_MAX_PORTS
) (
   input  logic [ehci_rb_pkg::OFFSET_W-1:0]   offset,
   input  logic [ehci_rb_pkg::PORT_NUM_W-1:0] num_ports,
   output ehci_rb_pkg::decode_type            decode
);

   localparam logic [ehci_rb_pkg::OFFSET_W-1:0] PORT_END =
      ehci_rb_pkg::OFFSET_W'(ehci_rb_pkg::OFS_PORT_BASE + 4 * MAX_PORTS);

   logic [ehci_rb_pkg::OFFSET_W-1:0]   port_delta;
   logic [ehci_rb_pkg::PORT_NUM_W-1:0] port_num;
   logic                               port_hit;

   // Any byte inside a port word selects that port.
   assign port_delta = offset - ehci_rb_pkg::OFS_PORT_BASE;
   assign port_num   = port_delta[ehci_rb_pkg::PORT_NUM_W+1:2];
   assign port_hit   = (offset >= ehci_rb_pkg::OFS_PORT_BASE) && (offset < PORT_END) &&
                       (port_num < num_ports);

   always_comb begin
      decode.port_num = port_num;
      unique case (offset)
         ehci_rb_pkg::OFS_CAP_LENGTH:  decode.sel = ehci_rb_pkg::SEL_CAP_LENGTH;
         ehci_rb_pkg::OFS_HCS_PARAMS:  decode.sel = ehci_rb_pkg::SEL_HCS_PARAMS;
         ehci_rb_pkg::OFS_HCC_PARAMS:  decode.sel = ehci_rb_pkg::SEL_HCC_PARAMS;
         ehci_rb_pkg::OFS_PORT_ROUTE:  decode.sel = ehci_rb_pkg::SEL_PORT_ROUTE;
         ehci_rb_pkg::OFS_COMMAND:     decode.sel = ehci_rb_pkg::SEL_COMMAND;
         ehci_rb_pkg::OFS_STATUS:      decode.sel = ehci_rb_pkg::SEL_STATUS;
         ehci_rb_pkg::OFS_INTR_ENABLE: decode.sel = ehci_rb_pkg::SEL_INTR_ENABLE;
         ehci_rb_pkg::OFS_FRAME_INDEX: decode.sel = ehci_rb_pkg::SEL_FRAME_INDEX;
         ehci_rb_pkg::OFS_SEGMENT:     decode.sel = ehci_rb_pkg::SEL_SEGMENT;
         ehci_rb_pkg::OFS_PERIODIC:    decode.sel = ehci_rb_pkg::SEL_PERIODIC;
         ehci_rb_pkg::OFS_ASYNC:       decode.sel = ehci_rb_pkg::SEL_ASYNC;
         ehci_rb_pkg::OFS_CONFIG_FLAG: decode.sel = ehci_rb_pkg::SEL_CONFIG_FLAG;
         default: begin
            decode.sel = port_hit ? ehci_rb_pkg::SEL_PORT : ehci_rb_pkg::SEL_NONE;
         end
      endcase
   end

endmodule

// ===== dv/ehci_host_register_bank_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of ehci_host_register_bank: directed and random bus accesses are
// scored against an in-bench model of the register map. Depends on ehci_rb_pkg and the RTL.

module ehci_host_register_bank_test;

   localparam int NUM_PORT_SLOTS  = ehci_rb_pkg::DEFAULT_MAX_PORTS;
   localparam int RSP_LATENCY     = 1;
   localparam int LONG_HOLD       = 300;
   localparam int STALL_LIMIT     = 2000;
   localparam int RANDOM_SEGMENTS = 16;
   localparam int SEGMENT_WORDS   = 96;
   localparam int PRESSURE_WORDS  = 40;

   typedef struct packed {
      logic                             kind;
      logic [ehci_rb_pkg::OFFSET_W-1:0] ofs;
      logic [ehci_rb_pkg::DATA_W-1:0]   wdata;
   } bus_access_type;

   typedef struct packed {
      logic [ehci_rb_pkg::OFFSET_W-1:0] ofs;
      logic [ehci_rb_pkg::DATA_W-1:0]   rdata;
      logic                             unmapped;
   } bank_reply_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_type = ehci_rb_pkg::REQ_READ;
   logic [ehci_rb_pkg::OFFSET_W-1:0]   req_offset = '0;
   logic [ehci_rb_pkg::DATA_W-1:0]     req_write_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [ehci_rb_pkg::DATA_W-1:0]     rsp_read_data;
   logic                               rsp_unmapped;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [ehci_rb_pkg::PORT_NUM_W-1:0] csr_num_ports = ehci_rb_pkg::NUM_PORTS_RESET;

   // Mirror of the register bank, updated as each word is accepted.
   logic [ehci_rb_pkg::PORT_NUM_W-1:0] port_count;
   logic [ehci_rb_pkg::DATA_W-1:0]     command_word, intr_enable_word, frame_index_word;
   logic [ehci_rb_pkg::DATA_W-1:0]     segment_word, periodic_word, async_word;
   logic [ehci_rb_pkg::DATA_W-1:0]     config_flag_word;
   logic [ehci_rb_pkg::DATA_W-1:0]     port_words [NUM_PORT_SLOTS];

   bank_reply_type awaited_replies [$];
   int             error_count = 0;
   int             send_idle_pct = 0;
   int             stall_pct = 0;
   int             cycle_count = 0;
   int             hold_until = 0;
   int             quiet_cycles = 0;

   ehci_host_register_bank dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_offset     (req_offset),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_unmapped   (rsp_unmapped),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_num_ports  (csr_num_ports)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void log_error(string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endfunction

   function automatic bank_reply_type bank_access(bus_access_type a);
      bank_reply_type r;
      int unsigned    slot;
      logic           port_hit;
      r = '0;
      r.ofs = a.ofs;
      slot = 0;
      port_hit = 1'b0;
      if (a.ofs >= ehci_rb_pkg::OFS_PORT_BASE &&
          a.ofs < ehci_rb_pkg::OFS_PORT_BASE + 4 * NUM_PORT_SLOTS) begin
         slot = (a.ofs - ehci_rb_pkg::OFS_PORT_BASE) >> 2;
         port_hit = slot < port_count;
      end
      if (a.kind == ehci_rb_pkg::REQ_WRITE) begin
         case (a.ofs)
            ehci_rb_pkg::OFS_COMMAND:
               command_word = a.wdata & ~ehci_rb_pkg::CMD_RESET_MASK;
            ehci_rb_pkg::OFS_INTR_ENABLE: intr_enable_word = a.wdata;
            ehci_rb_pkg::OFS_FRAME_INDEX: frame_index_word = a.wdata;
            ehci_rb_pkg::OFS_SEGMENT:     segment_word = a.wdata;
            ehci_rb_pkg::OFS_PERIODIC:    periodic_word = a.wdata;
            ehci_rb_pkg::OFS_ASYNC:       async_word = a.wdata;
            ehci_rb_pkg::OFS_CONFIG_FLAG: config_flag_word = a.wdata;
            ehci_rb_pkg::OFS_STATUS: begin
               // Writes to the status word have no effect and the word always reads the same.
            end
            default: begin
               if (port_hit) port_words[slot] = a.wdata;
               else r.unmapped = 1'b1;
            end
         endcase
      end else begin
         case (a.ofs)
            ehci_rb_pkg::OFS_CAP_LENGTH:  r.rdata = ehci_rb_pkg::CAP_WORD0;
            ehci_rb_pkg::OFS_HCS_PARAMS:
               r.rdata = ehci_rb_pkg::HCS_PARAMS_BASE | 32'(port_count);
            ehci_rb_pkg::OFS_HCC_PARAMS:  r.rdata = ehci_rb_pkg::HCC_PARAMS_VALUE;
            ehci_rb_pkg::OFS_PORT_ROUTE:  r.rdata = '0;
            ehci_rb_pkg::OFS_STATUS:      r.rdata = ehci_rb_pkg::STATUS_VALUE;
            ehci_rb_pkg::OFS_COMMAND:     r.rdata = command_word;
            ehci_rb_pkg::OFS_INTR_ENABLE: r.rdata = intr_enable_word;
            ehci_rb_pkg::OFS_FRAME_INDEX: r.rdata = frame_index_word;
            ehci_rb_pkg::OFS_SEGMENT:     r.rdata = segment_word;
            ehci_rb_pkg::OFS_PERIODIC:    r.rdata = periodic_word;
            ehci_rb_pkg::OFS_ASYNC:       r.rdata = async_word;
            ehci_rb_pkg::OFS_CONFIG_FLAG: r.rdata = config_flag_word;
            default: begin
               if (port_hit) r.rdata = port_words[slot];
               else r.unmapped = 1'b1;
            end
         endcase
      end
      return r;
   endfunction

   // Mostly aligned words in the mapped area, with unaligned port hits and raw noise.
   function automatic bus_access_type random_access();
      bus_access_type a;
      int unsigned    pick;
      a.kind = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 70) a.ofs = 12'($urandom_range(25) * 4);
      else if (pick < 85) begin
         a.ofs = ehci_rb_pkg::OFS_PORT_BASE + 12'($urandom_range(4 * NUM_PORT_SLOTS - 1));
      end
      else a.ofs = 12'($urandom);
      pick = $urandom_range(9);
      if (pick == 0) a.wdata = '0;
      else if (pick == 1) a.wdata = '1;
      else a.wdata = $urandom;
      return a;
   endfunction

   task automatic send_access(input logic kind,
                              input logic [ehci_rb_pkg::OFFSET_W-1:0] ofs,
                              input logic [ehci_rb_pkg::DATA_W-1:0] wdata);
      int             gap;
      bus_access_type a;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_offset <= ofs;
      req_write_data <= wdata;
      do @(posedge clock); while (req_stall !== 1'b0);
      a.kind = kind;
      a.ofs = ofs;
      a.wdata = wdata;
      awaited_replies.push_back(bank_access(a));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_port_count(input logic [ehci_rb_pkg::PORT_NUM_W-1:0] count);
      wait_for_drain();
      csr_valid <= 1'b1;
      csr_num_ports <= count;
      do @(posedge clock); while (csr_ready !== 1'b1);
      port_count = count;
      csr_valid <= 1'b0;
   endtask

   task automatic test_capability_words();
      send_access(ehci_rb_pkg::REQ_READ, ehci_rb_pkg::OFS_CAP_LENGTH, '0);
      send_access(ehci_rb_pkg::REQ_READ, ehci_rb_pkg::OFS_HCS_PARAMS, '0);
      send_access(ehci_rb_pkg::REQ_READ, ehci_rb_pkg::OFS_HCC_PARAMS, '0);
      send_access(ehci_rb_pkg::REQ_READ, ehci_rb_pkg::OFS_PORT_ROUTE, '0);
      send_access(ehci_rb_pkg::REQ_WRITE, ehci_rb_pkg::OFS_CAP_LENGTH, '1);
   endtask

   task automatic test_operational_registers();
      logic [ehci_rb_pkg::OFFSET_W-1:0] op_offsets [7] = '{
         ehci_rb_pkg::OFS_COMMAND, ehci_rb_pkg::OFS_INTR_ENABLE,
         ehci_rb_pkg::OFS_FRAME_INDEX, ehci_rb_pkg::OFS_SEGMENT,
         ehci_rb_pkg::OFS_PERIODIC, ehci_rb_pkg::OFS_ASYNC,
         ehci_rb_pkg::OFS_CONFIG_FLAG};
      foreach (op_offsets[i]) send_access(ehci_rb_pkg::REQ_WRITE, op_offsets[i], '1);
      foreach (op_offsets[i]) send_access(ehci_rb_pkg::REQ_READ, op_offsets[i], '0);
      send_access(ehci_rb_pkg::REQ_WRITE, ehci_rb_pkg::OFS_STATUS, '1);
      send_access(ehci_rb_pkg::REQ_READ, ehci_rb_pkg::OFS_STATUS, '0);
      // Fixed registers answer only at their exact offset.
      send_access(ehci_rb_pkg::REQ_READ, ehci_rb_pkg::OFS_COMMAND + 12'd1, '0);
      send_access(ehci_rb_pkg::REQ_WRITE, '1, '1);
   endtask

   task automatic test_port_window();
      write_port_count(4'd15);
      // An unaligned offset picks the port whose word contains it.
      send_access(ehci_rb_pkg::REQ_WRITE, ehci_rb_pkg::OFS_PORT_BASE + 12'd31,
                  32'hA5A5_5A5A);
      send_access(ehci_rb_pkg::REQ_READ, ehci_rb_pkg::OFS_PORT_BASE + 12'd28, '0);
      send_access(ehci_rb_pkg::REQ_READ, ehci_rb_pkg::OFS_PORT_BASE + 12'd32, '0);
      send_access(ehci_rb_pkg::REQ_READ, ehci_rb_pkg::OFS_HCS_PARAMS, '0);
      write_port_count(4'd0);
      send_access(ehci_rb_pkg::REQ_WRITE, ehci_rb_pkg::OFS_PORT_BASE + 12'd2, '1);
      send_access(ehci_rb_pkg::REQ_READ, ehci_rb_pkg::OFS_PORT_BASE, '0);
      send_access(ehci_rb_pkg::REQ_READ, ehci_rb_pkg::OFS_HCS_PARAMS, '0);
      write_port_count(ehci_rb_pkg::NUM_PORTS_RESET);
   endtask

   task automatic test_backpressure();
      bus_access_type a;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_until = cycle_count + LONG_HOLD;
      repeat (PRESSURE_WORDS) begin
         a = random_access();
         send_access(a.kind, a.ofs, a.wdata);
      end
      // The sender stays quiet until every outstanding word has come back.
      wait_for_drain();
   endtask

   task automatic test_random_traffic();
      int                                 send_mix [4] = '{0, 54, 0, 28};
      int                                 stall_mix [4] = '{0, 0, 54, 28};
      logic [ehci_rb_pkg::PORT_NUM_W-1:0] count_plan [3] = '{4'd15, 4'd0, 4'd8};
      bus_access_type                     a;
      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         if (seg % 4 == 3) write_port_count(4'($urandom_range(15)));
         else write_port_count(count_plan[seg % 4]);
         send_idle_pct = send_mix[seg / 4];
         stall_pct = stall_mix[seg / 4];
         repeat (SEGMENT_WORDS) begin
            a = random_access();
            send_access(a.kind, a.ofs, a.wdata);
         end
      end
   endtask

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(posedge clock) begin
      if (cycle_count < hold_until) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      bank_reply_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (awaited_replies.size() == 0) begin
            log_error($sformatf("unexpected response: data %h unmapped %b",
                                rsp_read_data, rsp_unmapped));
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_read_data !== want.rdata)
               log_error($sformatf("offset %h read_data: expected %h, got %h",
                                   want.ofs, want.rdata, rsp_read_data));
            if (rsp_unmapped !== want.unmapped)
               log_error($sformatf("offset %h unmapped: expected %b, got %b",
                                   want.ofs, want.unmapped, rsp_unmapped));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      port_count = ehci_rb_pkg::NUM_PORTS_RESET;
      command_word = '0;
      intr_enable_word = '0;
      frame_index_word = '0;
      segment_word = '0;
      periodic_word = '0;
      async_word = '0;
      config_flag_word = '0;
      foreach (port_words[i]) port_words[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 28;
      stall_pct = 28;
      test_capability_words();
      test_operational_registers();
      test_port_window();
      test_backpressure();
      test_random_traffic();
      wait_for_drain();
      if (error_count == 0 && awaited_replies.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== ehci_host_register_bank.f =====
rtl/ehci_rb_pkg.sv
rtl/ehci_rb_decode.sv
rtl/ehci_host_register_bank.sv
dv/ehci_host_register_bank_test.sv
